@@ src/rwtm_pkg.sv @@
// rwtm_pkg: shared types and constants of the rssi window trimmed-mean filter
// used by rwtm_ctrl, rwtm_dpath and rssi_window_trimmed_mean
// no dependencies
package rwtm_pkg;

	// default geometry
	localparam int DEF_WINDOW   = 10;
	localparam int DEF_CHANNELS = 4;

	// field widths
	localparam int CH_FIELD_W = 2;
	localparam int SMP_W      = 8;
	localparam int LVL_W      = 10;
	localparam int MAG_CFG_W  = 7;
	localparam int HYS_W      = 7;
	localparam int Q_SHIFT    = 2;

	// trimmed window: ranks TRIM_LO .. TOP_N-1 of the descending sort are summed
	localparam int TOP_N   = 6;
	localparam int TRIM_LO = 2;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic signed [SMP_W-1:0] RST_ACCEPT_FLOOR  = -8'sd85;
	localparam logic [MAG_CFG_W-1:0]    RST_MIN_MAGNITUDE = 7'd10;
	localparam logic [HYS_W-1:0]        RST_HYSTERESIS_DB = 7'd2;

	typedef enum logic [1:0] {
		REG_ACCEPT_FLOOR  = 2'd0,
		REG_MIN_MAGNITUDE = 2'd1,
		REG_HYSTERESIS_DB = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] accept_floor;
		logic [MAG_CFG_W-1:0]    min_magnitude;
		logic [HYS_W-1:0]        hysteresis_db;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic check;
		logic scan_init;
		logic scan;
		logic sum;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic complete;
		logic scan_last;
		logic out_free;
	} sts_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_SCAN  = 6'b000100,
		S_DRAIN = 6'b001000,
		S_SUM   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

endpackage

@@ src/rwtm_ctrl.sv @@
// rwtm_ctrl: sequencer of the trimmed-mean filter
// depends on rwtm_pkg; drives rwtm_dpath through cmd_t, watches sts_t
module rwtm_ctrl
	import rwtm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.complete) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ src/rwtm_dpath.sv @@
// rwtm_dpath: window memory, per-channel state, top-six insertion list, result register
// depends on rwtm_pkg; sequenced by rwtm_ctrl
module rwtm_dpath
	import rwtm_pkg::*;
#(
	parameter int WINDOW   = DEF_WINDOW,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [CH_FIELD_W-1:0]    channel,
	input  logic signed [SMP_W-1:0]  sample,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic [CH_FIELD_W-1:0]    channel_res,
	output logic signed [LVL_W-1:0]  level_q2,
	output logic                     updated,
	output logic                     first
);

	localparam int DEPTH = CHANNELS * WINDOW;
	localparam int AW    = $clog2(DEPTH);
	localparam int IDX_W = $clog2(WINDOW);
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DIF_W = LVL_W + 1;

	// captured item
	logic [CH_FIELD_W-1:0]   ch_q;
	logic signed [SMP_W-1:0] sample_q;

	// per-channel state
	logic [IDX_W-1:0]        fill_q [CHANNELS];
	logic [CHANNELS-1:0]     first_pend_q;
	logic signed [LVL_W-1:0] held_q [CHANNELS];

	// window memory
	logic signed [SMP_W-1:0] mem [DEPTH];
	logic signed [SMP_W-1:0] rd_data_s1;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_q;

	// descending list of the largest entries seen in the scan
	logic signed [SMP_W-1:0] top_q [TOP_N];
	logic [TOP_N-1:0]        top_vld_q;
	logic signed [SMP_W-1:0] top_d [TOP_N];
	logic [TOP_N-1:0]        top_vld_d;
	logic [TOP_N-1:0]        take;

	logic signed [LVL_W-1:0] sum_q;
	logic                    out_valid_q;

	logic [CH_W-1:0]         ch_idx;
	logic                    ch_ok;
	logic [SMP_W-1:0]        mag;
	logic                    pass;
	logic [IDX_W:0]          fill_inc;
	logic                    complete;
	logic [AW-1:0]           base;
	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic signed [LVL_W-1:0] trim_sum;
	logic signed [DIF_W-1:0] diff;
	logic [DIF_W-1:0]        diff_mag;
	logic                    take_new;

	assign ch_idx   = CH_W'(ch_q);
	assign ch_ok    = 32'(ch_q) < CHANNELS;
	assign mag      = sample_q[SMP_W-1] ? SMP_W'(-sample_q) : SMP_W'(sample_q);
	assign pass     = (mag > {1'b0, cfg.min_magnitude}) && (sample_q >= cfg.accept_floor);
	assign fill_inc = (IDX_W+1)'(fill_q[ch_idx]) + (IDX_W+1)'(1);
	assign complete = ch_ok && pass && (fill_inc == (IDX_W+1)'(WINDOW));
	assign base     = AW'(ch_idx) * AW'(WINDOW);
	assign wr_addr  = base + AW'(fill_q[ch_idx]);
	assign rd_addr  = base + AW'(rd_idx_q);
	assign wr_en    = cmd.check && ch_ok && pass;

	assign sts.complete  = complete;
	assign sts.scan_last = rd_idx_q == IDX_W'(WINDOW - 1);
	assign sts.out_free  = !out_valid_q || result_ready;

	// insertion of the read entry into the sorted list
	always_comb begin
		for (int i = 0; i < TOP_N; i++) begin
			take[i] = !top_vld_q[i] || (rd_data_s1 > top_q[i]);
		end
		top_d[0]     = take[0] ? rd_data_s1 : top_q[0];
		top_vld_d[0] = 1'b1;
		for (int i = 1; i < TOP_N; i++) begin
			if (!take[i]) begin
				top_d[i] = top_q[i];
			end else if (take[i-1]) begin
				top_d[i] = top_q[i-1];
			end else begin
				top_d[i] = rd_data_s1;
			end
			top_vld_d[i] = top_vld_q[i] || top_vld_q[i-1];
		end
	end

	always_comb begin
		trim_sum = '0;
		for (int i = TRIM_LO; i < TOP_N; i++) begin
			trim_sum = trim_sum + LVL_W'(top_q[i]);
		end
	end

	assign diff     = DIF_W'(sum_q) - DIF_W'(held_q[ch_idx]);
	assign diff_mag = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
	assign take_new = first_pend_q[ch_idx] ||
		(diff_mag > DIF_W'({cfg.hysteresis_db, {Q_SHIFT{1'b0}}}));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q     <= channel;
			sample_q <= sample;
		end
		if (wr_en) begin
			mem[wr_addr] <= sample_q;
		end
		rd_data_s1 <= mem[rd_addr];
		if (rd_vld_s1) begin
			for (int i = 0; i < TOP_N; i++) begin
				top_q[i] <= top_d[i];
			end
		end
		if (cmd.sum) begin
			sum_q <= trim_sum;
		end
		if (cmd.finish) begin
			channel_res <= ch_q;
			level_q2    <= take_new ? sum_q : held_q[ch_idx];
			updated     <= take_new;
			first       <= first_pend_q[ch_idx];
			if (take_new) begin
				held_q[ch_idx] <= sum_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				fill_q[c] <= '0;
			end
			first_pend_q <= '1;
			rd_vld_s1    <= 1'b0;
			rd_idx_q     <= '0;
			top_vld_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (wr_en) begin
				fill_q[ch_idx] <= complete ? '0 : fill_inc[IDX_W-1:0];
			end
			if (cmd.scan_init) begin
				rd_idx_q  <= '0;
				top_vld_q <= '0;
			end else begin
				if (cmd.scan) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				if (rd_vld_s1) begin
					top_vld_q <= top_vld_d;
				end
			end
			if (cmd.finish) begin
				out_valid_q          <= 1'b1;
				first_pend_q[ch_idx] <= 1'b0;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || result_ready))
		else $error("result register reloaded while an item still waits");
	a_list_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum |-> (&top_vld_q))
		else $error("trimmed sum taken before the sorted list is full");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.check && ch_ok) |-> (32'(fill_q[ch_idx]) < WINDOW))
		else $error("fill count reached the window size");
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && sts.scan_last) |=> (!cmd.scan && rd_vld_s1))
		else $error("window scan ran past its last entry");
`endif

endmodule

@@ src/rssi_window_trimmed_mean.sv @@
// rssi_window_trimmed_mean: top level with the configuration registers
// depends on rwtm_pkg, rwtm_ctrl and rwtm_dpath
//
// Per-channel trimmed-mean RSSI filter. Each item carries a beacon channel and a
// signed sample in dB; the sample enters the channel's window only when its
// magnitude exceeds min_magnitude and it is not below accept_floor, and a
// channel index at or above CHANNELS is dropped. When a window holds WINDOW
// samples it is read back one entry per cycle from a single window memory
// (CHANNELS*WINDOW entries) into a six-deep descending insertion list, and the
// 3rd to 6th largest values are summed into a level in quarter-dB. The first
// result of a channel is passed through with first=1; later results replace the
// held level only when they differ from it by more than 4*hysteresis_db,
// otherwise the held level is repeated with updated=0. An item that does not
// complete a window is only captured and checked; one that does has its window
// scanned through the one read port of the window memory, then drained and
// summed into a level. The result sits in an output register, so a new
// item is accepted while the previous result still waits; the result of a
// completing item holds the block only while that register is still full.
// The window memory needs no clearing pass after reset; entries are read only
// after they have been written. Configuration registers (APB, 32-bit data):
// 0x0 accept_floor (8 bits signed, reset -85), 0x4 min_magnitude (7 bits,
// reset 10), 0x8 hysteresis_db (7 bits, reset 2); write them only while idle.
module rssi_window_trimmed_mean
	import rwtm_pkg::*;
#(
	parameter int WINDOW   = DEF_WINDOW,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	// sample channel
	input  logic                    sample_valid,
	output logic                    sample_ready,
	input  logic [CH_FIELD_W-1:0]   channel,
	input  logic signed [SMP_W-1:0] sample,
	// result channel
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [CH_FIELD_W-1:0]   channel_res,
	output logic signed [LVL_W-1:0] level_q2,
	output logic                    updated,
	output logic                    first
);

	cfg_t     cfg_q;
	cmd_t     cmd;
	sts_t     sts;
	reg_idx_t reg_sel;
	logic     wr_strobe;

	assign pready    = 1'b1;
	// word address selects the register, byte offset ignored
	assign reg_sel   = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_strobe = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accept_floor  <= RST_ACCEPT_FLOOR;
			cfg_q.min_magnitude <= RST_MIN_MAGNITUDE;
			cfg_q.hysteresis_db <= RST_HYSTERESIS_DB;
		end else if (wr_strobe) begin
			unique case (reg_sel)
				REG_ACCEPT_FLOOR:  cfg_q.accept_floor  <= pwdata[SMP_W-1:0];
				REG_MIN_MAGNITUDE: cfg_q.min_magnitude <= pwdata[MAG_CFG_W-1:0];
				REG_HYSTERESIS_DB: cfg_q.hysteresis_db <= pwdata[HYS_W-1:0];
				default: ;
			endcase
		end
	end

	// read-back, floor sign-extended
	always_comb begin
		unique case (reg_sel)
			REG_ACCEPT_FLOOR:  prdata = PDATA_W'(cfg_q.accept_floor);
			REG_MIN_MAGNITUDE: prdata = PDATA_W'(cfg_q.min_magnitude);
			REG_HYSTERESIS_DB: prdata = PDATA_W'(cfg_q.hysteresis_db);
			default:           prdata = '0;
		endcase
	end

	rwtm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	rwtm_dpath #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.channel      (channel),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.channel_res  (channel_res),
		.level_q2     (level_q2),
		.updated      (updated),
		.first        (first)
	);

endmodule

@@ tb/sv/rssi_window_trimmed_mean_tb.sv @@
// rssi_window_trimmed_mean_tb: self-checking testbench for the per-channel trimmed-mean rssi filter
// holds the level scoreboard class, the apb and sample drivers and the result monitor
// depends on rwtm_pkg and rssi_window_trimmed_mean
module rssi_window_trimmed_mean_tb
	import rwtm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF         = 5;
	localparam int RESET_CYCLES     = 5;
	localparam int CYCLE_LIMIT      = 300000;
	// a completing item keeps the block busy through its window scan, leave room on top
	localparam int DRAIN_CYCLES     = DEF_WINDOW + 20;
	localparam int LONG_HOLD        = 400;
	localparam int RANDOM_PER_PHASE = 85;
	localparam int PHASES           = 6;
	localparam int MIN_RESULTS      = 48;
	localparam int REPORT_LIMIT     = 10;
	localparam int DIRECTED_N       = 18;

	// receiver stall patterns
	typedef enum int {
		RX_OPEN,
		RX_HALF,
		RX_SPARSE
	} rx_mode_t;

	// reference behavior of the filter plus the queue of expected levels
	class level_scoreboard;
		typedef struct {
			logic [CH_FIELD_W-1:0]   ch;
			logic signed [LVL_W-1:0] level;
			logic                    upd;
			logic                    fst;
		} level_rec_t;

		logic signed [SMP_W-1:0] floor_db;
		logic [MAG_CFG_W-1:0]    min_mag;
		logic [HYS_W-1:0]        hyst_db;
		logic signed [SMP_W-1:0] window_db [DEF_CHANNELS][DEF_WINDOW];
		int                      fill [DEF_CHANNELS];
		bit                      first_due [DEF_CHANNELS];
		int                      held_q2 [DEF_CHANNELS];
		level_rec_t              level_queue [$];
		int                      predicted;
		int                      errors;

		function new();
			floor_db = RST_ACCEPT_FLOOR;
			min_mag  = RST_MIN_MAGNITUDE;
			hyst_db  = RST_HYSTERESIS_DB;
			for (int c = 0; c < DEF_CHANNELS; c++) begin
				fill[c]      = 0;
				first_due[c] = 1'b1;
				held_q2[c]   = 0;
			end
			predicted = 0;
			errors    = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
			case (idx)
				REG_ACCEPT_FLOOR:  floor_db = val[SMP_W-1:0];
				REG_MIN_MAGNITUDE: min_mag  = val[MAG_CFG_W-1:0];
				REG_HYSTERESIS_DB: hyst_db  = val[HYS_W-1:0];
				default: ;
			endcase
		endfunction

		// magnitude strictly above the minimum and not below the floor
		function bit admits(logic signed [SMP_W-1:0] s);
			int v;
			int m;
			v = s;
			m = (v < 0) ? -v : v;
			return (m > int'(min_mag)) && (v >= int'(floor_db));
		endfunction

		// descending sort of the window, ranks TRIM_LO..TOP_N-1 summed
		function int trimmed_sum_q2(int ch);
			int ranked [DEF_WINDOW];
			int key;
			int j;
			int sum;
			for (int i = 0; i < DEF_WINDOW; i++) begin
				key = window_db[ch][i];
				j = i;
				while (j > 0 && ranked[j-1] < key) begin
					ranked[j] = ranked[j-1];
					j--;
				end
				ranked[j] = key;
			end
			sum = 0;
			for (int i = TRIM_LO; i < TOP_N; i++)
				sum += ranked[i];
			return sum;
		endfunction

		function void note_sample(logic [CH_FIELD_W-1:0] ch, logic signed [SMP_W-1:0] s);
			int sum;
			int diff;
			level_rec_t rec;
			if (admits(s)) begin
				window_db[ch][fill[ch]] = s;
				fill[ch]++;
			end
			if (fill[ch] < DEF_WINDOW)
				return;
			fill[ch] = 0;
			sum = trimmed_sum_q2(ch);
			diff = sum - held_q2[ch];
			if (diff < 0)
				diff = -diff;
			rec.ch  = ch;
			rec.fst = first_due[ch];
			if (first_due[ch] || diff > (int'(hyst_db) << Q_SHIFT)) begin
				held_q2[ch] = sum;
				rec.upd = 1'b1;
			end else begin
				rec.upd = 1'b0;
			end
			first_due[ch] = 1'b0;
			rec.level = LVL_W'(held_q2[ch]);
			level_queue.push_back(rec);
			predicted++;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%s", msg);
		endfunction

		function void check_level(logic [CH_FIELD_W-1:0] ch, logic signed [LVL_W-1:0] level,
				logic upd, logic fst);
			level_rec_t want;
			if (level_queue.size() == 0) begin
				flag($sformatf("unexpected level: ch %0d level %0d updated %0b first %0b",
					ch, level, upd, fst));
				return;
			end
			want = level_queue.pop_front();
			if (want.ch !== ch || want.level !== level || want.upd !== upd || want.fst !== fst)
				flag($sformatf({"level mismatch: expected ch %0d level %0d updated %0b first %0b,",
					" got ch %0d level %0d updated %0b first %0b"},
					want.ch, want.level, want.upd, want.fst, ch, level, upd, fst));
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [PADDR_W-1:0]      paddr;
	logic [PDATA_W-1:0]      pwdata;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;
	logic                    sample_valid;
	logic                    sample_ready;
	logic [CH_FIELD_W-1:0]   channel;
	logic signed [SMP_W-1:0] sample;
	logic                    result_valid;
	logic                    result_ready;
	logic [CH_FIELD_W-1:0]   channel_res;
	logic signed [LVL_W-1:0] level_q2;
	logic                    updated;
	logic                    first;

	// asks the result side for its one long hold-off
	bit hold_off_req = 1'b0;
	// per-channel center for clustered samples, chosen anew each phase
	int base_db [DEF_CHANNELS];

	level_scoreboard sb = new();

	// directed items: rejects on every rule, ten admitted values closing channel 0, one each on ch 3 and 2
	int dir_ch [DIRECTED_N] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3, 2};
	int dir_db [DIRECTED_N] = '{-128, 0, -10, 10, -86, -1, 127, -85, -11, 11,
		64, -50, -20, -70, 100, -30, -40, 127};

	// register settings per phase; phase 0 keeps the reset values
	int floor_tab [PHASES] = '{-85, -99,  0, -99, -60, -20};
	int mag_tab   [PHASES] = '{ 10,   0,  0,  99,  30,   5};
	int hyst_tab  [PHASES] = '{  2,   0, 99,  50,   2,   1};

	rssi_window_trimmed_mean dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.channel      (channel),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.channel_res  (channel_res),
		.level_q2     (level_q2),
		.updated      (updated),
		.first        (first)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// setup cycle then access cycle; the register takes the value at the access edge
	// psel stays up so back-to-back writes need no second assignment in one step
	task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
	endtask

	task automatic load_config(int floor_db, int min_mag, int hyst_db);
		apb_write(REG_ACCEPT_FLOOR, PDATA_W'(floor_db));
		apb_write(REG_MIN_MAGNITUDE, PDATA_W'(min_mag));
		apb_write(REG_HYSTERESIS_DB, PDATA_W'(hyst_db));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering items, wait for every expected level, then let the block go quiet
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (sb.level_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// valid stays up across back-to-back items; returns at the accepting edge
	task automatic push_sample(logic [CH_FIELD_W-1:0] ch, logic signed [SMP_W-1:0] s);
		sample_valid <= 1'b1;
		channel      <= ch;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
		sb.note_sample(ch, s);
	endtask

	function automatic logic signed [SMP_W-1:0] any_admitted();
		logic signed [SMP_W-1:0] cand;
		cand = '0;
		for (int t = 0; t < 256; t++) begin
			cand = SMP_W'($urandom_range(0, 255));
			if (sb.admits(cand))
				return cand;
		end
		return cand;
	endfunction

	// mostly admitted values, often clustered so the hysteresis hold gets exercised,
	// plus raw 8-bit noise that hits every bit and every reject rule
	function automatic logic signed [SMP_W-1:0] pick_sample(int ch);
		int r;
		logic signed [SMP_W-1:0] cand;
		r = $urandom_range(0, 99);
		if (r < 15)
			return SMP_W'($urandom_range(0, 255));
		if (r < 55) begin
			for (int t = 0; t < 16; t++) begin
				cand = SMP_W'(base_db[ch] + int'($urandom_range(0, 6)) - 3);
				if (sb.admits(cand))
					return cand;
			end
		end
		return any_admitted();
	endfunction

	// bursts of random length, random gaps, a gap-free burst about one time in four
	task automatic run_random(int n);
		int sent;
		int burst;
		int gap;
		logic [CH_FIELD_W-1:0] ch;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && sent < n) begin
				ch = CH_FIELD_W'($urandom_range(0, DEF_CHANNELS - 1));
				push_sample(ch, pick_sample(ch));
				sent++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stimulus and end of run
	initial begin : stimulus
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		sample_valid <= 1'b0;
		channel      <= '0;
		sample       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: floor -85, magnitude above 10, hysteresis 2 dB
		for (int i = 0; i < DIRECTED_N; i++)
			push_sample(CH_FIELD_W'(dir_ch[i]), SMP_W'(dir_db[i]));

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				// registers change only with the block idle
				wait_drained();
				load_config(floor_tab[ph], mag_tab[ph], hyst_tab[ph]);
			end
			for (int c = 0; c < DEF_CHANNELS; c++)
				base_db[c] = any_admitted();
			// long receiver hold-off while items keep coming, so the block backs up
			if (ph == 1)
				hold_off_req <= 1'b1;
			if (ph == 4) begin
				// sender pauses mid-phase until every level is out
				run_random(RANDOM_PER_PHASE / 2);
				wait_drained();
				run_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
			end else begin
				run_random(RANDOM_PER_PHASE);
			end
		end
		// keep going until enough windows have closed
		while (sb.predicted < MIN_RESULTS)
			run_random(20);

		wait_drained();
		if (sb.errors == 0 && sb.level_queue.size() == 0)
			$display("rssi_window_trimmed_mean_tb: clean");
		else
			$display("rssi_window_trimmed_mean_tb: errors");
		$finish;
	end

	// result side: checks each accepted level and stalls on a pattern of its own
	initial begin : result_side
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		bit hold_used;
		result_ready <= 1'b0;
		mode      = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		hold_used = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				sb.check_level(channel_res, level_q2, updated, first);
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (hold_off_req && !hold_used) begin
				// the one long hold-off, counted here
				hold_used = 1'b1;
				hold_left = LONG_HOLD - 1;
				result_ready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN: result_ready <= 1'b1;
					RX_HALF: result_ready <= 1'($urandom_range(0, 1));
					default: result_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// hard stop if the run hangs
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("rssi_window_trimmed_mean_tb: errors");
		$finish;
	end

endmodule
